>>> rtl/core/tgc_pkg.sv
// Shared types and constants for the touch gesture classifier.
package tgc_pkg;

	localparam logic [15:0] EVT_SYN = 16'd0;
	localparam logic [15:0] EVT_KEY = 16'd1;
	localparam logic [15:0] EVT_ABS = 16'd3;
	localparam logic [15:0] CODE_SYN_REPORT = 16'h0000;
	localparam logic [15:0] CODE_ABS_X = 16'h0000;
	localparam logic [15:0] CODE_ABS_Y = 16'h0001;
	localparam logic [15:0] CODE_MT_X = 16'h0035;
	localparam logic [15:0] CODE_MT_Y = 16'h0036;
	localparam logic [15:0] CODE_MT_TRACK = 16'h0039;
	localparam logic [15:0] CODE_BTN_LEFT = 16'h0110;
	localparam logic [15:0] CODE_BTN_TOUCH = 16'h014A;

	localparam logic [1:0] GEST_MOVE = 2'd0;
	localparam logic [1:0] GEST_TAP = 2'd1;
	localparam logic [1:0] GEST_SWIPE = 2'd2;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_XMIN = 3'd2;
	localparam logic [2:0] REG_XMAX = 3'd3;
	localparam logic [2:0] REG_YMIN = 3'd4;
	localparam logic [2:0] REG_YMAX = 3'd5;
	localparam logic [2:0] REG_MT = 3'd6;

	localparam logic [1:0] CMD_X = 2'd0;
	localparam logic [1:0] CMD_Y = 2'd1;
	localparam logic [1:0] CMD_START = 2'd2;
	localparam logic [1:0] CMD_SYNC = 2'd3;

	// decoded request from front to back
	typedef struct packed {
		logic [1:0] kind;
		logic rel;          // for start kind: release request
		logic [31:0] value;
	} cmd_t;

endpackage

>>> rtl/core/tgc_front.sv
// Front end: decodes input events into commands for the back end queue.
module tgc_front
	import tgc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic use_mt,
	input logic in_valid,
	output logic in_ready,
	input logic [15:0] ev_type,
	input logic [15:0] ev_code,
	input logic [31:0] ev_value,
	output logic cmd_valid,
	input logic cmd_ready,
	output cmd_t cmd
);
	logic [15:0] xcode, ycode;
	logic hit;
	cmd_t dec;
	logic valid_q;
	cmd_t cmd_q;

	assign xcode = use_mt ? CODE_MT_X : CODE_ABS_X;
	assign ycode = use_mt ? CODE_MT_Y : CODE_ABS_Y;

	always_comb begin
		hit = 1'b1;
		dec.value = ev_value;
		dec.rel = 1'b0;
		dec.kind = CMD_SYNC;
		if (ev_type == EVT_ABS && ev_code == xcode) begin
			dec.kind = CMD_X;
		end else if (ev_type == EVT_ABS && ev_code == ycode) begin
			dec.kind = CMD_Y;
		end else if (ev_type == EVT_ABS && ev_code == CODE_MT_TRACK) begin
			dec.kind = CMD_START;
			dec.rel = ev_value[31];
		end else if (ev_type == EVT_KEY &&
				(ev_code == CODE_BTN_TOUCH || ev_code == CODE_BTN_LEFT)) begin
			dec.kind = CMD_START;
			dec.rel = (ev_value == 32'd0);
		end else if (ev_type == EVT_SYN && ev_code == CODE_SYN_REPORT) begin
			dec.kind = CMD_SYNC;
		end else begin
			hit = 1'b0;
		end
	end

	assign in_ready = !valid_q || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			cmd_q <= dec;
		end
	end

	assign cmd_valid = valid_q;
	assign cmd = cmd_q;
endmodule

>>> rtl/core/tgc_fifo.sv
// Two-entry queue between front and back end.
module tgc_fifo
	import tgc_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic wr_valid,
	output logic wr_ready,
	input cmd_t wr_data,
	output logic rd_valid,
	input logic rd_ready,
	output cmd_t rd_data
);
	cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end
endmodule

>>> rtl/core/tgc_div.sv
// Serial restoring divider: 45-bit numerator by 33-bit divisor, one bit a cycle.
module tgc_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [44:0] num,
	input logic [32:0] den,
	output logic busy,
	output logic [11:0] quo
);
	logic [5:0] cnt_q;
	logic [44:0] n_q;
	logic [32:0] d_q;
	logic [33:0] r_q;
	logic [33:0] sh;
	logic [33:0] diff;

	assign sh = {r_q[32:0], n_q[44]};
	assign diff = sh - {1'b0, d_q};
	assign busy = cnt_q != 6'd0;
	assign quo = n_q[11:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 6'd0;
		end else if (start) begin
			cnt_q <= 6'd45;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			r_q <= 34'd0;
		end else if (busy) begin
			if (!diff[33]) begin
				r_q <= diff;
				n_q <= {n_q[43:0], 1'b1};
			end else begin
				r_q <= sh;
				n_q <= {n_q[43:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/core/tgc_back.sv
// Back end: touch state, scaling and gesture decision.
module tgc_back
	import tgc_pkg::*;
#(
	parameter int MAX_EXT = 4096
)(
	input logic clk,
	input logic arst_n,
	input logic [12:0] scr_w,
	input logic [12:0] scr_h,
	input logic [31:0] xmin,
	input logic [31:0] xmax,
	input logic [31:0] ymin,
	input logic [31:0] ymax,
	input logic cmd_valid,
	output logic cmd_ready,
	input cmd_t cmd,
	output logic busy,
	output logic res_valid,
	input logic res_ready,
	output logic [75:0] res_data
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DX = 2'd1;
	localparam logic [1:0] ST_DY = 2'd2;
	localparam logic [1:0] ST_DEC = 2'd3;
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_HELD = 2'd1;
	localparam logic [1:0] PH_NEW = 2'd2;

	logic [1:0] st_q;
	logic [31:0] rawx_q, rawy_q;
	logic [1:0] phase_q;
	logic rel_q;
	logic [11:0] bx_q, by_q, px_q, py_q, sx_q;
	logic res_v_q;
	logic [75:0] res_q;

	logic [12:0] w, h, ext;
	logic [31:0] raw, lo, hi;
	logic [32:0] vc, span;
	logic [44:0] num;
	logic dstart, dbusy;
	logic [11:0] dq;
	logic bad;

	function automatic logic [12:0] clamp_ext(input logic [12:0] e);
		if (e == 13'd0) return 13'd1;
		if ({19'd0, e} > MAX_EXT) return 13'(MAX_EXT);
		return e;
	endfunction

	// extent / 20 (at least 32) by reciprocal multiply (3277 / 2^16), exact for 13-bit extents
	function automatic logic [11:0] thr(input logic [12:0] e);
		logic [25:0] p;
		p = {13'd0, e} * 26'd3277;
		return (p[25:16] < 10'd32) ? 12'd32 : {2'd0, p[25:16]};
	endfunction

	assign w = clamp_ext(scr_w);
	assign h = clamp_ext(scr_h);
	assign bad = ($signed(xmax) <= $signed(xmin)) || ($signed(ymax) <= $signed(ymin));

	// X operands while idle (first divide starts there), Y operands after
	always_comb begin
		raw = (st_q == ST_IDLE) ? rawx_q : rawy_q;
		lo = (st_q == ST_IDLE) ? xmin : ymin;
		hi = (st_q == ST_IDLE) ? xmax : ymax;
		ext = (st_q == ST_IDLE) ? w : h;
		if ($signed(raw) < $signed(lo)) vc = 33'd0;
		else if ($signed(raw) > $signed(hi)) vc = {hi[31], hi} - {lo[31], lo};
		else vc = {raw[31], raw} - {lo[31], lo};
		span = {hi[31], hi} - {lo[31], lo};
		num = vc * {20'd0, ext - 13'd1};
	end

	assign cmd_ready = (st_q == ST_IDLE) && !res_v_q;
	assign dstart = ((st_q == ST_IDLE) && cmd_valid && cmd_ready && cmd.kind == CMD_SYNC
		&& !bad) || ((st_q == ST_DX) && !dbusy);
	assign busy = st_q != ST_IDLE;

	tgc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(num), .den(span),
		.busy(dbusy), .quo(dq)
	);

	logic [11:0] x, y, nbx, nby, ax, ay;
	logic [12:0] dx, dy;
	logic tap_hit, swipe_hit;
	logic [1:0] gcode;
	assign x = sx_q;
	assign y = dq;
	assign nbx = (phase_q == PH_NEW) ? x : bx_q;
	assign nby = (phase_q == PH_NEW) ? y : by_q;
	assign dx = {1'b0, x} - {1'b0, nbx};
	assign dy = {1'b0, y} - {1'b0, nby};
	assign ax = dx[12] ? 12'(-dx) : dx[11:0];
	assign ay = dy[12] ? 12'(-dy) : dy[11:0];
	assign tap_hit = (ax <= 12'd15) && (ay <= 12'd15);
	assign swipe_hit = (ax >= thr(w)) || (ay >= thr(h));
	assign gcode = !rel_q ? GEST_MOVE : (tap_hit ? GEST_TAP : GEST_SWIPE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rawx_q <= '0; rawy_q <= '0;
			phase_q <= PH_IDLE; rel_q <= 1'b0;
			bx_q <= '0; by_q <= '0; px_q <= '0; py_q <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_v_q && res_ready) res_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					if (cmd_valid && cmd_ready) begin
						case (cmd.kind)
							CMD_X: rawx_q <= cmd.value;
							CMD_Y: rawy_q <= cmd.value;
							CMD_START: begin
								if (!cmd.rel && phase_q == PH_IDLE) phase_q <= PH_NEW;
								else if (cmd.rel && phase_q != PH_IDLE) rel_q <= 1'b1;
							end
							default: if (!bad) st_q <= ST_DX;
						endcase
					end
				end
				ST_DX: if (!dbusy) st_q <= ST_DY;
				ST_DY: if (!dbusy && !dstart) st_q <= ST_DEC;
				ST_DEC: begin
					st_q <= ST_IDLE;
					res_q <= {dy, dx, nby, nbx, y, x, gcode};
					if (phase_q == PH_NEW) begin
						bx_q <= x; by_q <= y; px_q <= x; py_q <= y;
					end
					if (rel_q) begin
						phase_q <= PH_IDLE; rel_q <= 1'b0;
						res_v_q <= tap_hit || swipe_hit;
					end else if (phase_q == PH_NEW) begin
						phase_q <= PH_HELD;
					end else if (phase_q == PH_HELD && (x != px_q || y != py_q)) begin
						res_v_q <= 1'b1;
						px_q <= x; py_q <= y;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DX && !dbusy) sx_q <= dq;
	end

	assign res_valid = res_v_q;
	assign res_data = res_q;
endmodule

>>> rtl/core/touch_gesture_classifier.sv
// Top level of the touch gesture classifier.
// Input: raw input events on s_axis (type, code, value), one per request.
// Position, tracking and key events update touch state; a sync report
// scales the latched raw coordinates to the screen and may produce one
// gesture request on m_axis (move, tap or swipe with positions and deltas).
// Config: cfg_valid/cfg_ready with cfg_index (0..6) and cfg_data; write only
// while idle; cfg_ready is low while the back end works on a sync report.
// Out-of-range indexes are ignored.
// Flow: non-sync events pass through the decode register and the two-entry
// queue. A sync report runs two serial 45-step divisions (one per axis) in
// the back end's shared divider, then the decision, before any result on
// m_axis; the back end takes no new command until it is done. Other events
// drain at one per cycle while the back end is idle and no result is pending.
// Reset: clears config to defaults (800x480, axes 0..4095, single-touch
// codes) and all touch state; no clearing pass.
// Receiver stall: a pending result holds in the output register and the back
// end stops taking commands; the queue and front keep absorbing events
// until they fill, then s_axis_tready drops.
module touch_gesture_classifier
	import tgc_pkg::*;
#(
	parameter int MAX_SCREEN_EXTENT = 4096
)(
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [63:0] s_axis_tdata,  // event_type, event_code, event_value
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// gesture, pos_x, pos_y, origin_x, origin_y, delta_x, delta_y
	output logic [79:0] m_axis_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic [12:0] w_q, h_q;
	logic [31:0] xmin_q, xmax_q, ymin_q, ymax_q;
	logic mt_q;
	logic fv, fr, qv, qr, bbusy;
	cmd_t fc, qc;
	logic [75:0] res;

	assign cfg_ready = !bbusy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 13'd800; h_q <= 13'd480;
			xmin_q <= '0; xmax_q <= 32'd4095;
			ymin_q <= '0; ymax_q <= 32'd4095;
			mt_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH: w_q <= cfg_data[12:0];
				REG_HEIGHT: h_q <= cfg_data[12:0];
				REG_XMIN: xmin_q <= cfg_data;
				REG_XMAX: xmax_q <= cfg_data;
				REG_YMIN: ymin_q <= cfg_data;
				REG_YMAX: ymax_q <= cfg_data;
				REG_MT: mt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	tgc_front u_front (
		.clk(clk), .arst_n(arst_n), .use_mt(mt_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.ev_type(s_axis_tdata[15:0]), .ev_code(s_axis_tdata[31:16]),
		.ev_value(s_axis_tdata[63:32]),
		.cmd_valid(fv), .cmd_ready(fr), .cmd(fc)
	);

	tgc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fc),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qc)
	);

	tgc_back #(.MAX_EXT(MAX_SCREEN_EXTENT)) u_back (
		.clk(clk), .arst_n(arst_n), .scr_w(w_q), .scr_h(h_q),
		.xmin(xmin_q), .xmax(xmax_q), .ymin(ymin_q), .ymax(ymax_q),
		.cmd_valid(qv), .cmd_ready(qr), .cmd(qc), .busy(bbusy),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
	);

	assign m_axis_tdata = {4'd0, res};
endmodule

>>> rtl/core/tgc_checker.sv
// Port-level checker for the touch gesture classifier, bound to the top level.
module tgc_checker (
	input logic clk,
	input logic arst_n,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [79:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped under stall");
	a_gest: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3)
		else $error("bad gesture code");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:76] == 4'd0)
		else $error("pad bits set");
	// a tap never moves more than 15 pixels on X
	a_tap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] == 2'd1 |->
		$signed(m_axis_tdata[62:50]) <= 13'sd15 && $signed(m_axis_tdata[62:50]) >= -13'sd15)
		else $error("tap delta");
endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
